FILE: hw/rtl/cct_pkg.sv
// Shared types and constants for the co-occurrence cosine top-N block.
// No dependencies.
`default_nettype none
package cct_pkg;

    localparam int MAX_USERS_DEF = 1024;
    localparam int MAX_TOPN_DEF  = 32;

    localparam int ID_W    = 10;
    localparam int CNT_W   = 16;
    localparam int SCORE_W = 17;
    localparam int TOPN_W  = 6;
    localparam int UCNT_W  = 11;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_N      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_COUNT = 4'd1;

    localparam logic [TOPN_W-1:0] TOP_N_RESET      = 6'd10;
    localparam logic [UCNT_W-1:0] USER_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } cell_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cct_cell.sv
// One cell of the sorted top-N chain: holds an entry, takes a candidate or
// its upper neighbor on insert, takes its lower neighbor on shift. Uses cct_pkg.
`default_nettype none
module cct_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        enable,
    input  wire logic                        insert,
    input  wire logic                        shift,
    input  wire logic [cct_pkg::ID_W-1:0]    cand_id,
    input  wire logic [cct_pkg::SCORE_W-1:0] cand_score,
    input  wire logic                        beat_prev,
    input  wire cct_pkg::cell_t              prev_cell,
    input  wire cct_pkg::cell_t              next_cell,
    output logic                             beat,
    output cct_pkg::cell_t                   entry
);
    import cct_pkg::*;

    cell_t cell_reg, cell_next;

    assign beat = insert && enable && (!cell_reg.valid || (cand_score > cell_reg.score));
    assign entry = cell_reg;

    always_comb begin
        cell_next = cell_reg;
        if (shift) begin
            cell_next = next_cell;
        end else if (beat) begin
            if (beat_prev) begin
                cell_next = prev_cell;
            end else begin
                cell_next.valid = 1'b1;
                cell_next.id    = cand_id;
                cell_next.score = cand_score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
        cell_reg.id    <= cell_next.id;
        cell_reg.score <= cell_next.score;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cct_score.sv
// Cosine score unit: floor(sqrt(co^2 * 2^32 / prod)) capped at 1.0, one
// quotient bit then one root bit per cycle. Uses cct_pkg.
`default_nettype none
module cct_score (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [31:0]                 cosq,
    input  wire logic [31:0]                 prod,
    output logic                             done,
    output logic [cct_pkg::SCORE_W-1:0]      score
);
    import cct_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} state_t;

    state_t             state_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        quot_reg;
    logic [31:0]        prod_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        val_reg;
    logic [31:0]        res_reg;
    logic [31:0]        bit_reg;
    logic               done_reg;
    logic               done_next;
    logic [SCORE_W-1:0] score_reg;

    logic [32:0] rem2;
    logic        ge;
    logic [31:0] quot_next;
    logic [32:0] trial;

    assign rem2      = {rem_reg, 1'b0};
    assign ge        = rem2 >= {1'b0, prod_reg};
    assign quot_next = {quot_reg[30:0], ge};
    assign trial     = {1'b0, res_reg} + {1'b0, bit_reg};
    assign done      = done_reg;
    assign score     = score_reg;
    assign done_next = ((state_reg == S_IDLE) && start && (cosq >= prod))
                       || ((state_reg == S_SQRT) && (bit_reg == 32'd1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= done_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        prod_reg <= prod;
                        rem_reg  <= cosq;
                        quot_reg <= '0;
                        cnt_reg  <= '0;
                        if (cosq >= prod) begin
                            score_reg <= SCORE_ONE;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    rem_reg  <= ge ? 32'(rem2 - {1'b0, prod_reg}) : rem2[31:0];
                    quot_reg <= quot_next;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        val_reg   <= quot_next;
                        res_reg   <= '0;
                        bit_reg   <= 32'h4000_0000;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if ({1'b0, val_reg} >= trial) begin
                        val_reg <= 32'({1'b0, val_reg} - trial);
                        res_reg <= (res_reg >> 1) + bit_reg;
                        if (bit_reg == 32'd1) begin
                            score_reg <= SCORE_W'((res_reg >> 1) + bit_reg);
                        end
                    end else begin
                        res_reg <= res_reg >> 1;
                        if (bit_reg == 32'd1) begin
                            score_reg <= SCORE_W'(res_reg >> 1);
                        end
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 32'd1) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cooccurrence_cosine_topn.sv
// Co-occurrence cosine top-N: a set item is written straight from idle; an add reads
// the count and writes it back in S_CO_WR. A finish reads the query degree in S_QDEG,
// then sweeps all MAX_USERS entries, scoring each candidate user in the shared
// divide/root unit, then emits one result per cycle from the cell chain while the output is not stalled.
// Reset clears the degree and count memories in a sweep over all MAX_USERS addresses
// during which no item is taken. Uses cct_pkg, cct_cell, cct_score.
`default_nettype none
module cooccurrence_cosine_topn #(
    parameter int MAX_USERS = cct_pkg::MAX_USERS_DEF,
    parameter int MAX_TOPN  = cct_pkg::MAX_TOPN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // user_id[9:0], item_count[25:10], zero fill
    input  wire logic [31:0]                   s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // neighbor_id[9:0], score[26:10], found[27], zero fill
    output logic [31:0]                        m_tdata,
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cct_pkg::CFG_DAT_W-1:0] cfg_data
);
    import cct_pkg::*;

    localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int LW = $clog2(MAX_TOPN + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_USERS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CO_WR, S_QDEG, S_SCAN_RD, S_SCAN_DAT,
        S_START, S_WAIT, S_INS, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       addr_reg;
    logic [TOPN_W-1:0]   top_n_reg;
    logic [UCNT_W-1:0]   user_count_reg;
    logic [AW-1:0]       q_reg;
    logic                qok_reg;
    logic [CNT_W-1:0]    nq_reg;
    logic [AW:0]         scan_reg;
    logic [LW-1:0]       lim_reg;
    logic [31:0]         cosq_reg;
    logic [31:0]         prod_reg;
    logic [ID_W-1:0]     cand_id_reg;
    logic [SCORE_W-1:0]  cand_score_reg;
    logic                m_tvalid_reg;
    logic [31:0]         m_tdata_reg;
    logic                m_tlast_reg;

    logic [CNT_W-1:0] deg_mem [MAX_USERS];
    logic [CNT_W-1:0] co_mem  [MAX_USERS];
    logic [CNT_W-1:0] deg_rd_reg;
    logic [CNT_W-1:0] co_rd_reg;

    logic [1:0]       req;
    logic [ID_W-1:0]  uid;
    logic [CNT_W-1:0] item_cnt;
    logic             uid_ok;
    logic             s_acc;
    logic [AW-1:0]    mem_addr;
    logic             deg_we;
    logic [CNT_W-1:0] deg_wdata;
    logic             co_we;
    logic [CNT_W-1:0] co_wdata;
    logic             cand;
    logic             out_free;
    logic             score_done;
    logic [SCORE_W-1:0] score_val;
    logic             ins_pulse;
    logic             shift_pulse;

    cell_t cells [MAX_TOPN];
    logic  beats [MAX_TOPN];

    assign req      = s_tuser;
    assign uid      = s_tdata[ID_W-1:0];
    assign item_cnt = s_tdata[ID_W+CNT_W-1:ID_W];
    assign uid_ok   = 32'(uid) < 32'(MAX_USERS);
    assign s_tready = state_reg == S_IDLE;
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign cand = (co_rd_reg != '0) && !(qok_reg && (addr_reg == q_reg))
                  && ({1'b0, addr_reg} < scan_reg);
    assign ins_pulse   = state_reg == S_INS;
    assign shift_pulse = (state_reg == S_EMIT) && out_free && cells[0].valid;

    always_comb begin
        mem_addr  = addr_reg;
        deg_we    = 1'b0;
        deg_wdata = '0;
        co_we     = 1'b0;
        co_wdata  = '0;
        unique case (state_reg)
            S_CLEAR: begin
                deg_we = 1'b1;
                co_we  = 1'b1;
            end
            S_IDLE: begin
                mem_addr  = AW'(uid);
                deg_wdata = item_cnt;
                deg_we    = s_acc && (req == REQ_SET) && uid_ok;
            end
            S_CO_WR: begin
                co_we    = 1'b1;
                co_wdata = (co_rd_reg == '1) ? co_rd_reg : co_rd_reg + 1'b1;
            end
            S_SCAN_RD: co_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[mem_addr] <= deg_wdata;
        end
        deg_rd_reg <= deg_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (co_we) begin
            co_mem[mem_addr] <= co_wdata;
        end
        co_rd_reg <= co_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_n_reg      <= TOP_N_RESET;
            user_count_reg <= USER_COUNT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_TOP_N) begin
                top_n_reg <= cfg_data[TOPN_W-1:0];
            end else if (cfg_index == CFG_USER_COUNT) begin
                user_count_reg <= cfg_data[UCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == LAST_ADDR) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        addr_reg <= AW'(uid);
                        if (req == REQ_ADD && uid_ok) begin
                            state_reg <= S_CO_WR;
                        end else if (req == REQ_FINISH) begin
                            q_reg    <= AW'(uid);
                            qok_reg  <= uid_ok;
                            lim_reg  <= (top_n_reg == '0) ? LW'(1) :
                                        (32'(top_n_reg) > 32'(MAX_TOPN)) ? LW'(MAX_TOPN) :
                                        LW'(top_n_reg);
                            scan_reg <= (32'(user_count_reg) > 32'(MAX_USERS)) ?
                                        (AW+1)'(MAX_USERS) : (AW+1)'(user_count_reg);
                            state_reg <= S_QDEG;
                        end
                    end
                end
                S_CO_WR: state_reg <= S_IDLE;
                S_QDEG: begin
                    nq_reg    <= qok_reg ? deg_rd_reg : '0;
                    addr_reg  <= '0;
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD: state_reg <= S_SCAN_DAT;
                S_SCAN_DAT: begin
                    cosq_reg    <= co_rd_reg * co_rd_reg;
                    prod_reg    <= nq_reg * deg_rd_reg;
                    cand_id_reg <= ID_W'(addr_reg);
                    if (cand) begin
                        state_reg <= S_START;
                    end else if (addr_reg == LAST_ADDR) begin
                        state_reg <= S_EMIT;
                    end else begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_START: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (score_done) begin
                        cand_score_reg <= score_val;
                        state_reg      <= S_INS;
                    end
                end
                S_INS: begin
                    if (addr_reg == LAST_ADDR) begin
                        state_reg <= S_EMIT;
                    end else begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (!cells[0].valid) begin
                            m_tdata_reg <= '0;
                            m_tlast_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end else begin
                            m_tdata_reg <= {4'd0, 1'b1, cells[0].score, cells[0].id};
                            if (MAX_TOPN == 1 || !cells[(MAX_TOPN > 1) ? 1 : 0].valid) begin
                                m_tlast_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else begin
                                m_tlast_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    cct_score u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_START),
        .cosq    (cosq_reg),
        .prod    (prod_reg),
        .done    (score_done),
        .score   (score_val)
    );

    for (genvar i = 0; i < MAX_TOPN; i++) begin : g_cell
        cell_t prev_c;
        cell_t next_c;
        logic  beat_p;
        if (i == 0) begin : g_first
            assign prev_c = '0;
            assign beat_p = 1'b0;
        end else begin : g_mid
            assign prev_c = cells[i-1];
            assign beat_p = beats[i-1];
        end
        if (i == MAX_TOPN - 1) begin : g_last
            assign next_c = '0;
        end else begin : g_inner
            assign next_c = cells[i+1];
        end
        cct_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .enable     (LW'(i) < lim_reg),
            .insert     (ins_pulse),
            .shift      (shift_pulse),
            .cand_id    (cand_id_reg),
            .cand_score (cand_score_reg),
            .beat_prev  (beat_p),
            .prev_cell  (prev_c),
            .next_cell  (next_c),
            .beat       (beats[i]),
            .entry      (cells[i])
        );
    end

endmodule
`default_nettype wire

FILE: verif/cooccurrence_cosine_topn_tb.sv
// Self-checking testbench for cooccurrence_cosine_topn: directed table and
// random load/finish sequences under several idle patterns, checked against a local predictor.
// Depends on cct_pkg and cooccurrence_cosine_topn.
`timescale 1ns / 100ps
module cooccurrence_cosine_topn_tb;
    import cct_pkg::*;

    localparam int NUSR = 1024;
    localparam int NTOP = 32;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic               found;
        logic               last;
    } nbr_t;

    typedef struct {
        logic [1:0]         req;
        logic [ID_W-1:0]    uid;
        logic [CNT_W-1:0]   cnt;
        bit                 chk;
        logic [ID_W-1:0]    exp_id;
        logic [SCORE_W-1:0] exp_score;
        logic               exp_found;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    cooccurrence_cosine_topn dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [CNT_W-1:0]   degree_mem [NUSR];
    logic [CNT_W-1:0]   cocount_mem [NUSR];
    logic [TOPN_W-1:0]  top_n_reg = TOP_N_RESET;
    logic [UCNT_W-1:0]  ucount_reg = USER_COUNT_RESET;
    logic [ID_W-1:0]    rank_id [NTOP];
    logic [SCORE_W-1:0] rank_score [NTOP];

    nbr_t neighbor_q[$];
    int   err_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_start = 0;
    int   hold_left = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("cooccurrence_cosine_topn regression: fail");
        $finish;
    end

    function automatic logic [SCORE_W-1:0] cosine_score(int unsigned co, int unsigned nq,
                                                       int unsigned nv);
        longint unsigned prod, quot, r, t;
        prod = longint'(nq) * longint'(nv);
        if (prod == 0) return SCORE_ONE;
        quot = ((longint'(co) * longint'(co)) << 32) / prod;
        if (quot >= (64'd1 << 32)) return SCORE_ONE;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= quot) r = t;
        end
        return r[SCORE_W-1:0];
    endfunction

    function automatic void rank_neighbors(logic [ID_W-1:0] q, bit push);
        int unsigned lim, scan, fill, pos, j;
        logic [SCORE_W-1:0] sc;
        nbr_t n;
        lim = (top_n_reg < 1) ? 1 : (top_n_reg > NTOP) ? NTOP : top_n_reg;
        scan = (ucount_reg > NUSR) ? NUSR : ucount_reg;
        cocount_mem[q] = '0;
        fill = 0;
        for (int unsigned v = 0; v < scan; v++) begin
            if (cocount_mem[v] != 0) begin
                sc = cosine_score(cocount_mem[v], degree_mem[q], degree_mem[v]);
                pos = fill;
                while (pos > 0 && sc > rank_score[pos-1]) pos--;
                if (pos < lim) begin
                    j = (fill < lim) ? fill : lim - 1;
                    for (; j > pos; j--) begin
                        rank_id[j] = rank_id[j-1];
                        rank_score[j] = rank_score[j-1];
                    end
                    rank_id[pos] = v[ID_W-1:0];
                    rank_score[pos] = sc;
                    if (fill < lim) fill++;
                end
            end
        end
        foreach (cocount_mem[i]) cocount_mem[i] = '0;
        if (!push) return;
        if (fill == 0) begin
            n = '{id: '0, score: '0, found: 1'b0, last: 1'b1};
            neighbor_q.push_back(n);
        end
        for (int unsigned k = 0; k < fill; k++) begin
            n = '{id: rank_id[k], score: rank_score[k], found: 1'b1, last: (k + 1 == fill)};
            neighbor_q.push_back(n);
        end
    endfunction

    function automatic void apply_item(logic [1:0] req, logic [ID_W-1:0] uid,
                                       logic [CNT_W-1:0] cnt, bit push);
        case (req)
            REQ_SET: degree_mem[uid] = cnt;
            REQ_ADD: if (cocount_mem[uid] != 16'hFFFF) cocount_mem[uid] = cocount_mem[uid] + 16'd1;
            REQ_FINISH: rank_neighbors(uid, push);
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] req, logic [ID_W-1:0] uid, logic [CNT_W-1:0] cnt,
                             bit push = 1);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {6'd0, cnt, uid};
        do @(posedge aclk); while (!s_tready);
        apply_item(req, uid, cnt, push);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TOP_N) top_n_reg = val[TOPN_W-1:0];
        else if (idx == CFG_USER_COUNT) ucount_reg = val[UCNT_W-1:0];
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (neighbor_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [CNT_W-1:0] pick_degree();
        case ($urandom_range(3))
            0: return '0;
            1: return CNT_W'($urandom_range(1, 8));
            2: return CNT_W'($urandom_range(1, 300));
            default: return CNT_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic run_queries(int n_items);
        int sent, span, nu, q, u;
        span = (ucount_reg == 0) ? 1 : (ucount_reg > NUSR) ? NUSR : ucount_reg;
        sent = 0;
        while (sent < n_items) begin
            q = ($urandom_range(3) == 0) ? $urandom_range(NUSR - 1) : $urandom_range(span - 1);
            if ($urandom_range(3) != 0) begin
                send_item(REQ_SET, ID_W'(q), pick_degree());
                sent++;
            end
            nu = $urandom_range(1, 24);
            for (int i = 0; i < nu && sent < n_items - 1; i++) begin
                u = ($urandom_range(4) == 0) ? $urandom_range(NUSR - 1)
                                             : $urandom_range(span - 1);
                if ($urandom_range(1)) begin
                    send_item(REQ_SET, ID_W'(u), pick_degree());
                    sent++;
                end
                repeat ($urandom_range(1, 2)) begin
                    send_item(REQ_ADD, ($urandom_range(9) == 0) ? ID_W'(q) : ID_W'(u),
                              CNT_W'($urandom));
                    sent++;
                end
                if ($urandom_range(9) == 0) begin
                    send_item(2'($urandom_range(3)), ID_W'($urandom), CNT_W'($urandom));
                    sent++;
                end
            end
            send_item(REQ_FINISH, ID_W'(q), CNT_W'($urandom));
            sent++;
        end
    endtask

    always @(posedge aclk) begin
        nbr_t e;
        if (hold_start) begin
            hold_left = 6000;
            hold_start = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (m_tvalid && m_tready) begin
            if (neighbor_q.size() == 0) begin
                $error("unexpected result id=%0d", m_tdata[9:0]);
                err_cnt++;
            end else begin
                e = neighbor_q.pop_front();
                if (m_tdata[9:0] !== e.id) begin
                    $error("neighbor_id exp %0d got %0d", e.id, m_tdata[9:0]);
                    err_cnt++;
                end
                if (m_tdata[26:10] !== e.score) begin
                    $error("score exp %0d got %0d", e.score, m_tdata[26:10]);
                    err_cnt++;
                end
                if (m_tdata[27] !== e.found) begin
                    $error("found exp %0d got %0d", e.found, m_tdata[27]);
                    err_cnt++;
                end
                if (m_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    row_t dir_tab[] = '{
        '{REQ_FINISH, 10'd0,    16'd0,     1, 10'd0,    17'd0,     1'b0},
        '{REQ_SET,    10'd1,    16'd4,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_SET,    10'd2,    16'd4,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd2,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd2,    16'hFFFF,  0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd1,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_FINISH, 10'd1,    16'd0,     1, 10'd2,    17'd32768, 1'b1},
        '{REQ_SET,    10'd3,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd3,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_NONE,   10'd3,    16'hFFFF,  0, 10'd0,    17'd0,     1'b0},
        '{REQ_FINISH, 10'd1,    16'd0,     1, 10'd3,    17'h10000, 1'b1},
        '{REQ_SET,    10'd1023, 16'hFFFF,  0, 10'd0,    17'd0,     1'b0},
        '{REQ_SET,    10'd0,    16'hFFFF,  0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd0,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_FINISH, 10'd1023, 16'd0,     1, 10'd0,    17'd1,     1'b1},
        '{REQ_SET,    10'd5,    16'd9,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_SET,    10'd6,    16'd2,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_SET,    10'd1022, 16'd7,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd5,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd6,    16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd1022, 16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_ADD,    10'd1023, 16'd0,     0, 10'd0,    17'd0,     1'b0},
        '{REQ_FINISH, 10'd1,    16'd0,     0, 10'd0,    17'd0,     1'b0}
    };

    initial begin
        nbr_t e;
        foreach (degree_mem[i]) degree_mem[i] = '0;
        foreach (cocount_mem[i]) cocount_mem[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].req, dir_tab[i].uid, dir_tab[i].cnt, !dir_tab[i].chk);
            if (dir_tab[i].chk) begin
                e = '{id: dir_tab[i].exp_id, score: dir_tab[i].exp_score,
                      found: dir_tab[i].exp_found, last: 1'b1};
                neighbor_q.push_back(e);
            end
        end
        drain();

        run_queries(70);
        drain();

        write_reg(CFG_TOP_N, 16'd32);
        write_reg(CFG_USER_COUNT, 16'd1024);
        send_idle_pct = 85;
        run_queries(70);
        drain();

        write_reg(CFG_TOP_N, 16'hFFC1);
        write_reg(CFG_USER_COUNT, 16'hF801);
        write_reg(4'd2, 16'hFFFF);
        write_reg(4'd15, 16'h0000);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        hold_start = 1;
        run_queries(70);
        drain();

        write_reg(CFG_TOP_N, 16'd0);
        write_reg(CFG_USER_COUNT, 16'd0);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        run_queries(40);
        drain();

        write_reg(CFG_TOP_N, 16'd63);
        write_reg(CFG_USER_COUNT, 16'd2047);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1;
        run_queries(90);
        drain();

        write_reg(CFG_TOP_N, CFG_DAT_W'($urandom_range(1, 32)));
        write_reg(CFG_USER_COUNT, CFG_DAT_W'($urandom_range(1, 1024)));
        send_idle_pct = 33;
        recv_stall_pct = 33;
        run_queries(70);
        drain();

        if (err_cnt == 0) begin
            $display("cooccurrence_cosine_topn regression: pass");
        end else begin
            $display("cooccurrence_cosine_topn regression: fail");
        end
        $finish;
    end
endmodule
